// File: hw/rtl/wt_pkg.sv
// Word tokenizer package: sizes, opcode codes and byte classification.
// Used by the channel interfaces, the word RAM users and the top level.
// No dependencies.
`default_nettype none

package wt_pkg;

  // Word buffer size and derived widths
  localparam int MAX_WORD = 64;
  localparam int LEN_W    = $clog2(MAX_WORD + 1);
  localparam int ADDR_W   = $clog2(MAX_WORD);
  localparam int BYTE_W   = 8;

  // Opcodes of the input channel
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [BYTE_W-1:0] CHAR_HYPHEN = 8'h2D;

  // Letters: ASCII A-Z, a-z and every byte with the top bit set
  function automatic logic is_letter(input logic [BYTE_W-1:0] c);
    return c inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h80:8'hFF]};
  endfunction

  // Whitespace plus the punctuation set that closes a word
  function automatic logic is_separator(input logic [BYTE_W-1:0] c);
    return c inside {8'h20, [8'h09:8'h0D],
                     8'h2E, 8'h2C, 8'h3B, 8'h3A, 8'h21, 8'h3F,
                     8'h28, 8'h29, 8'h5B, 8'h5D, 8'h7B, 8'h7D,
                     8'h22, 8'h27, 8'h2A, 8'h2B, 8'h3D, 8'h2F,
                     8'h5C, 8'h5F, 8'h23, 8'h24, 8'h25, 8'h26,
                     8'h40, 8'h5E, 8'h60, 8'h3C, 8'h3E, 8'h7C,
                     8'h7E};
  endfunction

  // Lower ASCII capitals, pass everything else
  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c inside {[8'h41:8'h5A]}) begin
      r = c | 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/wt_if.sv
// Valid/ready channel interfaces of the word tokenizer: text in, word bytes out.
// Depends on wt_pkg.
`default_nettype none

interface wt_in_if
  import wt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [BYTE_W-1:0] text_byte;

  modport source (output valid, output opcode, output text_byte, input ready);
  modport sink   (input valid, input opcode, input text_byte, output ready);
endinterface

interface wt_out_if
  import wt_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] word_char;
  logic              word_end;
  logic              truncated;

  modport source (output valid, output word_char, output word_end, output truncated,
                  input ready);
  modport sink   (input valid, input word_char, input word_end, input truncated,
                  output ready);
endinterface

`default_nettype wire

// File: hw/rtl/wt_word_ram.sv
// Simple dual-port RAM for the word buffer: one write port, one registered read.
// Self-contained; read data appears in the cycle after the address.
`default_nettype none

module wt_word_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [DATA_W-1:0]        wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/word_tokenizer.sv
// Word tokenizer top level: collects text bytes into the word RAM and
// streams each finished word out. Depends on wt_pkg, wt_if, wt_word_ram.
//
// Usage:
//   text_in carries one item per text byte (opcode 0) or an end-of-text
//   marker (opcode 1). word_out carries one item per byte of an emitted word,
//   capitals lowered, word_end on the last byte and truncated on every byte
//   of a word longer than 64 bytes.
//   Throughput: while a word is being collected, one byte is taken each cycle.
//   A separator or end marker that closes a word with a letter in it starts
//   the read-out: ready drops and the buffer is walked through the single
//   read port, one byte at a time (read, then load the output register);
//   no new read is issued before the previous byte is loaded, and the input
//   is held until the read of the last stored byte is issued.
//   Words without a letter are dropped in the same cycle.
//   Once the closing item is accepted, the first word byte reaches word_out
//   through the RAM read register and then the output register.
//   Stall: when word_out.ready is low the output register holds its item and
//   no further buffer reads are issued; read-out resumes when it drains.
//   Reset: rst (synchronous) empties the open word and the output register.
//   The buffer RAM is not cleared; only bytes written for the open word are
//   ever read back.
`default_nettype none

module word_tokenizer
  import wt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  wt_in_if.sink     text_in,
  wt_out_if.source  word_out
);

  localparam logic S_COLLECT = 1'b0;
  localparam logic S_EMIT    = 1'b1;

  logic              state;
  logic [LEN_W-1:0]  word_length;
  logic              seen_letter;
  logic [BYTE_W-1:0] previous_char;
  logic              overflowed;

  logic [ADDR_W-1:0] rd_idx;
  logic [ADDR_W-1:0] emit_last;
  logic              emit_trunc;
  logic              rd_pending;
  logic              pend_last;

  logic              out_valid;
  logic [BYTE_W-1:0] out_char;
  logic              out_end;
  logic              out_trunc;

  logic              in_fire;
  logic              is_close;
  logic              do_join;
  logic              has_room;
  logic              mem_we;
  logic              start_emit;
  logic              can_issue;
  logic [BYTE_W-1:0] rd_data;

  // Classify the incoming item
  always_comb begin
    in_fire    = text_in.valid && text_in.ready;
    is_close   = (text_in.opcode == OP_END) || is_separator(text_in.text_byte);
    do_join    = !is_close &&
                 ((text_in.text_byte != CHAR_HYPHEN) ||
                  ((word_length != '0) && is_letter(previous_char)));
    has_room   = word_length < LEN_W'(MAX_WORD);
    mem_we     = in_fire && do_join && has_room;
    start_emit = in_fire && is_close && (word_length != '0) && seen_letter;
    can_issue  = (state == S_EMIT) && !rd_pending && (!out_valid || word_out.ready);
  end

  assign text_in.ready = (state == S_COLLECT);

  wt_word_ram #(
    .DATA_W (BYTE_W),
    .DEPTH  (MAX_WORD)
  ) u_word_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (word_length[ADDR_W-1:0]),
    .wdata (text_in.text_byte),
    .raddr (rd_idx),
    .rdata (rd_data)
  );

  // Open-word bookkeeping and the collect/emit sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_COLLECT;
      word_length   <= '0;
      seen_letter   <= 1'b0;
      previous_char <= '0;
      overflowed    <= 1'b0;
    end else begin
      if (in_fire) begin
        if (is_close) begin
          word_length   <= '0;
          seen_letter   <= 1'b0;
          previous_char <= '0;
          overflowed    <= 1'b0;
          if (start_emit) begin
            state <= S_EMIT;
          end
        end else if (do_join) begin
          if (has_room) begin
            word_length <= word_length + LEN_W'(1);
          end else begin
            overflowed <= 1'b1;
          end
          previous_char <= text_in.text_byte;
          if (is_letter(text_in.text_byte)) begin
            seen_letter <= 1'b1;
          end
        end
      end
      if (can_issue && (rd_idx == emit_last)) begin
        state <= S_COLLECT;
      end
    end
  end

  // Latch the word shape and advance the read pointer
  always_ff @(posedge clk) begin
    if (start_emit) begin
      emit_last  <= ADDR_W'(word_length - LEN_W'(1));
      emit_trunc <= overflowed;
      rd_idx     <= '0;
    end else if (can_issue && (rd_idx != emit_last)) begin
      rd_idx <= rd_idx + ADDR_W'(1);
    end
    if (can_issue) begin
      pend_last <= (rd_idx == emit_last);
    end
  end

  // Track the read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pending <= 1'b0;
    end else begin
      rd_pending <= can_issue;
    end
  end

  // Output register: load returning read data, drop on handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rd_pending) begin
      out_valid <= 1'b1;
    end else if (word_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_pending) begin
      out_char  <= to_lower(rd_data);
      out_end   <= pend_last;
      out_trunc <= emit_trunc;
    end
  end

  assign word_out.valid     = out_valid;
  assign word_out.word_char = out_char;
  assign word_out.word_end  = out_end;
  assign word_out.truncated = out_trunc;

  // A returning read always finds the output register free
  a_pending_room: assert property (@(posedge clk) disable iff (rst)
    rd_pending |-> !out_valid)
    else $error("read data returned while output register is full");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    word_length <= LEN_W'(MAX_WORD))
    else $error("word length beyond buffer size");

  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT) |-> (rd_idx <= emit_last))
    else $error("read pointer past end of word");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    start_emit |=> (state == S_EMIT) && (word_length == '0) && !seen_letter)
    else $error("closing a word did not clear it and start read-out");

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Testbench for word_tokenizer: drives text bytes and end markers, and checks
// every emitted word byte against a cycle-free model of the tokenizer.
// Depends on wt_pkg, wt_if and the word_tokenizer RTL.
`timescale 1ns / 1ps

module testbench
  import wt_pkg::*;
;

  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 20;

  // Opening items: no-word separators, hyphen rules, letterless and high bytes
  localparam logic [8:0] DIRECTED [23] = '{
    {OP_BYTE, 8'h20}, {OP_END, 8'h41},
    {OP_BYTE, CHAR_HYPHEN}, {OP_BYTE, 8'h41}, {OP_BYTE, 8'h5A}, {OP_BYTE, CHAR_HYPHEN},
    {OP_BYTE, 8'h39}, {OP_BYTE, CHAR_HYPHEN}, {OP_BYTE, 8'h61}, {OP_BYTE, 8'h7A},
    {OP_BYTE, 8'h2C},
    {OP_BYTE, 8'h31}, {OP_BYTE, 8'h32}, {OP_BYTE, CHAR_HYPHEN}, {OP_BYTE, 8'h30},
    {OP_BYTE, 8'h09},
    {OP_BYTE, 8'h80}, {OP_BYTE, 8'hFF}, {OP_BYTE, 8'h00}, {OP_BYTE, 8'h7F},
    {OP_END, 8'hFF},
    {OP_BYTE, 8'h71}, {OP_BYTE, 8'h0D}
  };

  // Word model plus the queue of word bytes still owed by the block
  class tokenizer_scoreboard;
    typedef struct {
      logic [BYTE_W-1:0] ch;
      logic              last;
      logic              trunc;
    } word_byte_t;

    word_byte_t        expected_q [$];
    logic [BYTE_W-1:0] word_buf [MAX_WORD];
    int unsigned       word_len;
    bit                has_letter;
    logic [BYTE_W-1:0] last_joined;
    bit                lost_bytes;
    int unsigned       errors = 0;
    int unsigned       bytes_checked = 0;
    int unsigned       words_expected = 0;
    int unsigned       truncated_words = 0;

    function new();
      clear_word();
    endfunction

    static function bit letter_byte(logic [BYTE_W-1:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c[7];
    endfunction

    static function bit separator_byte(logic [BYTE_W-1:0] c);
      bit r;
      r = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
      case (c)
        8'h2E, 8'h2C, 8'h3B, 8'h3A, 8'h21, 8'h3F, 8'h28, 8'h29,
        8'h5B, 8'h5D, 8'h7B, 8'h7D, 8'h22, 8'h27, 8'h2A, 8'h2B,
        8'h3D, 8'h2F, 8'h5C, 8'h5F, 8'h23, 8'h24, 8'h25, 8'h26,
        8'h40, 8'h5E, 8'h60, 8'h3C, 8'h3E, 8'h7C, 8'h7E: r = 1'b1;
        default: ;
      endcase
      return r;
    endfunction

    function void clear_word();
      word_len    = 0;
      has_letter  = 1'b0;
      last_joined = '0;
      lost_bytes  = 1'b0;
    endfunction

    // Store while room is left; past the buffer only mark the loss
    function void join_byte(logic [BYTE_W-1:0] c);
      if (word_len < MAX_WORD) begin
        word_buf[word_len] = c;
        word_len++;
      end else begin
        lost_bytes = 1'b1;
      end
      last_joined = c;
      if (letter_byte(c)) has_letter = 1'b1;
    endfunction

    // Queue the open word, lowered, if it holds a letter; then forget it
    function void close_word();
      word_byte_t        wb;
      logic [BYTE_W-1:0] c;
      if (word_len != 0 && has_letter) begin
        words_expected++;
        if (lost_bytes) truncated_words++;
        for (int i = 0; i < word_len; i++) begin
          c = word_buf[i];
          if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
          wb.ch    = c;
          wb.last  = (i == word_len - 1);
          wb.trunc = lost_bytes;
          expected_q = {expected_q, wb};
        end
      end
      clear_word();
    endfunction

    function void note_input(logic op, logic [BYTE_W-1:0] b);
      if (op == OP_END || separator_byte(b)) begin
        close_word();
      end else if (b == CHAR_HYPHEN) begin
        if (word_len != 0 && letter_byte(last_joined)) join_byte(b);
      end else begin
        join_byte(b);
      end
    endfunction

    function void check_result(logic [BYTE_W-1:0] ch, logic last, logic trunc);
      word_byte_t wb;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected word byte %h end=%b trunc=%b", $time, ch, last, trunc);
        return;
      end
      wb = expected_q.pop_front();
      bytes_checked++;
      if (wb.ch !== ch || wb.last !== last || wb.trunc !== trunc) begin
        errors++;
        if (errors <= 10)
          $display("%0t: word byte mismatch: expected %h end=%b trunc=%b, got %h end=%b trunc=%b",
                   $time, wb.ch, wb.last, wb.trunc, ch, last, trunc);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst;
  wt_in_if  text_in ();
  wt_out_if word_out ();

  word_tokenizer u_dut (
    .clk      (clk),
    .rst      (rst),
    .text_in  (text_in),
    .word_out (word_out)
  );

  tokenizer_scoreboard sb;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;
  int unsigned items_sent     = 0;

  initial begin
    clk = 1'b0;
  end
  always #10 clk = ~clk;

  // Check accepted word bytes, then pick the next ready value
  always @(posedge clk) begin
    if (!rst && word_out.valid && word_out.ready)
      sb.check_result(word_out.word_char, word_out.word_end, word_out.truncated);
    word_out.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (text_in.valid && text_in.ready) || (word_out.valid && word_out.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no item accepted for %0d cycles", IDLE_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item after random idle cycles and hold it until taken
  task automatic send_item(input logic op, input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      text_in.valid <= 1'b0;
      @(posedge clk);
    end
    text_in.valid     <= 1'b1;
    text_in.opcode    <= op;
    text_in.text_byte <= b;
    do @(posedge clk); while (!text_in.ready);
    sb.note_input(op, b);
    items_sent++;
  endtask

  // Hold the input until every owed word byte has come out
  task automatic wait_for_words();
    text_in.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [BYTE_W-1:0] pick_word_byte(bit letters_ok);
    int unsigned       r;
    logic [BYTE_W-1:0] b;
    r = $urandom_range(99);
    if (letters_ok && r < 50) begin
      b = ($urandom_range(1) != 0 ? 8'h41 : 8'h61) + 8'($urandom_range(25));
    end else if (letters_ok && r < 62) begin
      b = 8'($urandom_range(255, 128));
    end else if (r < 78) begin
      b = 8'h30 + 8'($urandom_range(9));
    end else if (r < 88) begin
      b = CHAR_HYPHEN;
    end else begin
      do b = 8'($urandom_range(127));
      while (tokenizer_scoreboard::letter_byte(b) ||
             tokenizer_scoreboard::separator_byte(b) || b == CHAR_HYPHEN);
    end
    return b;
  endfunction

  // One word: mostly short, now and then around the buffer size, then a closer
  task automatic send_word();
    int unsigned       len;
    bit                letters_ok;
    logic [BYTE_W-1:0] b;
    letters_ok = ($urandom_range(99) >= 15);
    len = ($urandom_range(99) < 8) ? $urandom_range(68, 62) : $urandom_range(9, 1);
    for (int i = 0; i < len; i++) send_item(OP_BYTE, pick_word_byte(letters_ok));
    if ($urandom_range(99) < 15) begin
      send_item(OP_END, 8'($urandom));
    end else begin
      do b = 8'($urandom); while (!tokenizer_scoreboard::separator_byte(b));
      send_item(OP_BYTE, b);
    end
  endtask

  // Raw bytes and end markers with no structure
  task automatic send_noise();
    repeat ($urandom_range(4, 1))
      send_item(($urandom_range(3) == 0) ? OP_END : OP_BYTE, 8'($urandom));
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                           input int unsigned n_items);
    int unsigned goal;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      if ($urandom_range(99) < 15) send_noise();
      else send_word();
    end
    send_item(OP_END, 8'($urandom));
    wait_for_words();
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    text_in.valid     = 1'b0;
    text_in.opcode    = OP_BYTE;
    text_in.text_byte = '0;
    word_out.ready    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed opening with no idling
    foreach (DIRECTED[i]) send_item(DIRECTED[i][8], DIRECTED[i][7:0]);
    wait_for_words();

    // Random words under each idling mix
    run_phase(0, 0, 50);
    run_phase(70, 0, 50);
    run_phase(0, 70, 50);
    run_phase(9, 9, 50);

    wait_for_words();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d text items over four idling mixes; checked %0d word bytes",
             items_sent, sb.bytes_checked);
    $display("in %0d words, %0d of them cut at the buffer size; %0d mismatches",
             sb.words_expected, sb.truncated_words, sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
